@@ hdl/hsic_pkg.sv @@
package hsic_pkg;

  localparam int unsigned IDX_W   = 60;
  localparam int unsigned RING_W  = (IDX_W + 1) / 2;
  localparam int unsigned STEP_W  = $clog2(RING_W);
  localparam int unsigned CELLS_W = IDX_W + 3;
  localparam int unsigned LEN_W   = RING_W + 1;
  localparam int unsigned POS_W   = RING_W + 4;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned SIDES   = 6;

  typedef enum logic [2:0] {
    SIDE_0 = 3'd0,
    SIDE_1 = 3'd1,
    SIDE_2 = 3'd2,
    SIDE_3 = 3'd3,
    SIDE_4 = 3'd4,
    SIDE_5 = 3'd5
  } hsic_side_e;

  typedef struct packed {
    logic               zero;
    logic [IDX_W-1:0]   idx;
    logic [CELLS_W-1:0] cells;
    logic [RING_W-1:0]  ring;
  } hsic_srch_t;

  typedef struct packed {
    logic             zero;
    hsic_side_e       side;
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
  } hsic_side_t;

endpackage

@@ hdl/hsic_ring_stage.sv @@
module hsic_ring_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [hsic_pkg::STEP_W-1:0] step_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  hsic_pkg::hsic_srch_t       data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output hsic_pkg::hsic_srch_t       data_o
);
  import hsic_pkg::*;

  logic               valid_q;
  hsic_srch_t         data_q;
  hsic_srch_t         data_d;
  logic [RING_W-1:0]  bit_w;
  logic [RING_W-1:0]  ring_try;
  logic [CELLS_W-1:0] base;
  logic [CELLS_W-1:0] inc;
  logic [CELLS_W-1:0] cells_try;

  // Setting bit b of t raises 3t(t+1) by 3 * 2^b * (2t + 2^b + 1).
  always_comb begin
    bit_w     = RING_W'(1) << step_i;
    ring_try  = data_i.ring | bit_w;
    base      = (CELLS_W'(data_i.ring) << 1) + CELLS_W'(bit_w) + CELLS_W'(1);
    inc       = base << step_i;
    cells_try = data_i.cells + inc + (inc << 1);
    data_d    = data_i;
    if (cells_try < CELLS_W'(data_i.idx)) begin
      data_d.ring  = ring_try;
      data_d.cells = cells_try;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

@@ hdl/hsic_side_sel.sv @@
module hsic_side_sel (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsic_pkg::hsic_srch_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsic_pkg::hsic_side_t data_o
);
  import hsic_pkg::*;

  logic             a_valid_q;
  logic             a_zero_q;
  logic [POS_W-1:0] a_pos_q;
  logic [POS_W-1:0] a_pos_d;
  logic [LEN_W-1:0] a_len_q;
  logic [LEN_W-1:0] a_len_d;
  logic [POS_W-1:0] a_mult_q [SIDES-1];
  logic [POS_W-1:0] a_mult_d [SIDES-1];
  logic             a_ready;

  logic             b_valid_q;
  hsic_side_t       b_data_q;
  hsic_side_t       b_data_d;
  logic [POS_W-1:0] sub;
  logic             b_ready;

  // The position within the ring is the index less the cells of the inner rings.
  always_comb begin
    a_pos_d     = POS_W'(data_i.idx) - POS_W'(data_i.cells);
    a_len_d     = LEN_W'(data_i.ring) + LEN_W'(1);
    a_mult_d[0] = POS_W'(a_len_d);
    a_mult_d[1] = a_mult_d[0] << 1;
    a_mult_d[2] = a_mult_d[1] + a_mult_d[0];
    a_mult_d[3] = a_mult_d[0] << 2;
    a_mult_d[4] = a_mult_d[3] + a_mult_d[0];
  end

  always_comb begin
    b_data_d.zero = a_zero_q;
    b_data_d.len  = a_len_q;
    if (a_pos_q <= a_mult_q[0]) begin
      b_data_d.side = SIDE_0;
      sub           = '0;
    end else if (a_pos_q <= a_mult_q[1]) begin
      b_data_d.side = SIDE_1;
      sub           = a_mult_q[0];
    end else if (a_pos_q <= a_mult_q[2]) begin
      b_data_d.side = SIDE_2;
      sub           = a_mult_q[1];
    end else if (a_pos_q <= a_mult_q[3]) begin
      b_data_d.side = SIDE_3;
      sub           = a_mult_q[2];
    end else if (a_pos_q <= a_mult_q[4]) begin
      b_data_d.side = SIDE_4;
      sub           = a_mult_q[3];
    end else begin
      b_data_d.side = SIDE_5;
      sub           = a_mult_q[4];
    end
    b_data_d.pos = a_pos_q - sub;
  end

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign data_o  = b_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) begin
      a_zero_q <= data_i.zero;
      a_pos_q  <= a_pos_d;
      a_len_q  <= a_len_d;
      a_mult_q <= a_mult_d;
    end
    if (b_ready && a_valid_q) begin
      b_data_q <= b_data_d;
    end
  end

endmodule

@@ hdl/hsic_coord.sv @@
module hsic_coord (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  hsic_pkg::hsic_side_t                data_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [hsic_pkg::COORD_W-1:0] coord_x_o,
  output logic signed [hsic_pkg::COORD_W-1:0] coord_y_o
);
  import hsic_pkg::*;

  logic                      valid_q;
  logic signed [COORD_W-1:0] x_q;
  logic signed [COORD_W-1:0] y_q;
  logic [COORD_W-1:0]        x_d;
  logic [COORD_W-1:0]        y_d;
  logic [COORD_W-1:0]        s;
  logic [COORD_W-1:0]        r;

  // Each side of the ring is a straight run between two corners.
  always_comb begin
    s = COORD_W'(data_i.len);
    r = COORD_W'(data_i.pos);
    unique case (data_i.side)
      SIDE_0: begin
        x_d = (s << 1) - r;
        y_d = r << 1;
      end
      SIDE_1: begin
        x_d = s - (r << 1);
        y_d = s << 1;
      end
      SIDE_2: begin
        x_d = '0 - s - r;
        y_d = (s << 1) - (r << 1);
      end
      SIDE_3: begin
        x_d = r - (s << 1);
        y_d = '0 - (r << 1);
      end
      SIDE_4: begin
        x_d = (r << 1) - s;
        y_d = '0 - (s << 1);
      end
      SIDE_5: begin
        x_d = s + r;
        y_d = (r << 1) - (s << 1);
      end
      default: begin
        x_d = '0;
        y_d = '0;
      end
    endcase
    if (data_i.zero) begin
      x_d = '0;
      y_d = '0;
    end
  end

  assign ready_o   = !valid_q || ready_i;
  assign valid_o   = valid_q;
  assign coord_x_o = x_q;
  assign coord_y_o = y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

@@ hdl/hex_spiral_index_to_coord.sv @@
// Maps a cell index on a hexagonal spiral around the origin to the cell's
// coordinates in doubled hex coordinates, where the neighbours of a cell lie
// at (+-2,0) and (+-1,+-2); index 0 gives (0,0). The ring is found by a
// pipelined bit-by-bit search, one bit of the ring number per stage. An item
// passes through RING_W search stages, two stages that pick the side of the
// ring and the offset along it, and the output register. A new item is
// accepted every cycle unless the output side stalls.
module hex_spiral_index_to_coord (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hsic_pkg::IDX_W-1:0]          spiral_index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hsic_pkg::COORD_W-1:0] coord_x_o,
  output logic signed [hsic_pkg::COORD_W-1:0] coord_y_o
);
  import hsic_pkg::*;

  logic       srch_valid [RING_W+1];
  logic       srch_ready [RING_W+1];
  hsic_srch_t srch_data  [RING_W+1];
  logic       side_valid;
  logic       side_ready;
  hsic_side_t side_data;

  always_comb begin
    srch_valid[0]      = in_valid_i;
    srch_data[0].zero  = (spiral_index_i == '0);
    srch_data[0].idx   = spiral_index_i;
    srch_data[0].cells = '0;
    srch_data[0].ring  = '0;
  end

  assign in_ready_o = srch_ready[0];

  for (genvar g = 0; g < RING_W; g++) begin : g_ring
    hsic_ring_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (STEP_W'(RING_W - 1 - g)),
      .valid_i (srch_valid[g]),
      .ready_o (srch_ready[g]),
      .data_i  (srch_data[g]),
      .valid_o (srch_valid[g+1]),
      .ready_i (srch_ready[g+1]),
      .data_o  (srch_data[g+1])
    );
  end

  hsic_side_sel u_side_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (srch_valid[RING_W]),
    .ready_o (srch_ready[RING_W]),
    .data_i  (srch_data[RING_W]),
    .valid_o (side_valid),
    .ready_i (side_ready),
    .data_o  (side_data)
  );

  hsic_coord u_coord (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (side_valid),
    .ready_o   (side_ready),
    .data_i    (side_data),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .coord_x_o (coord_x_o),
    .coord_y_o (coord_y_o)
  );

`ifndef SYNTHESIS
  // Every cell of the doubled grid has an even row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coord_y_o[0] == 1'b0))
    else $error("odd row on a result item");

  // Column and half-row always share parity on the doubled grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coord_x_o[0] == coord_y_o[1]))
    else $error("result item off the hex grid");

  // Back-pressure at the input can only come from a stall at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output drains");

  // An item leaving the search carries a ring whose cell count lies below its index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (srch_valid[RING_W] && !srch_data[RING_W].zero) |->
      (srch_data[RING_W].cells < CELLS_W'(srch_data[RING_W].idx)))
    else $error("ring search overshot the index");
`endif

endmodule

@@ sim/tb_hex_spiral_index_to_coord.sv @@
module tb_hex_spiral_index_to_coord;
  import hsic_pkg::*;

  localparam longint unsigned RING_SEARCH_TOP = 64'd1_000_000_000;
  localparam longint unsigned BIG_RING        = 64'd619_000_000;
  localparam int unsigned     RANDOM_PER_PASS = 360;
  localparam int unsigned     DRAIN_CYCLES    = 60;
  localparam int unsigned     CYCLE_LIMIT     = 400_000;

  typedef struct {
    logic [IDX_W-1:0]          idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } hex_cell_t;

  class hex_coord_board;
    hex_cell_t   pending_q[$];
    int unsigned mismatches;

    static function longint unsigned ring_cells(longint unsigned m);
      if (m == 0) begin
        return 64'd1;
      end
      return 64'd3 * m * m - 64'd3 * m + 64'd1;
    endfunction

    static function hex_cell_t locate_cell(logic [IDX_W-1:0] idx);
      hex_cell_t       c;
      longint unsigned n, lo, hi, mid;
      longint          k, side, r, x, y;
      x = 0;
      y = 0;
      if (idx != '0) begin
        n  = 64'(idx) + 64'd1;
        lo = 64'd1;
        hi = RING_SEARCH_TOP;
        while (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (ring_cells(mid) >= n) begin
            hi = mid;
          end else begin
            lo = mid + 64'd1;
          end
        end
        k    = longint'(lo);
        side = k - 1;
        r    = longint'(n - ring_cells(lo - 64'd1));
        if (r <= side) begin
          x = 2 * k - r - 2;
          y = 2 * r;
        end else if (r <= 2 * side) begin
          r = r - side;
          x = k - 1 - 2 * r;
          y = 2 * k - 2;
        end else if (r <= 3 * side) begin
          r = r - 2 * side;
          x = -k + 1 - r;
          y = 2 * k - 2 - 2 * r;
        end else if (r <= 4 * side) begin
          r = r - 3 * side;
          x = -2 * k + 2 + r;
          y = -2 * r;
        end else if (r <= 5 * side) begin
          r = r - 4 * side;
          x = -k + 1 + 2 * r;
          y = -2 * k + 2;
        end else begin
          r = r - 5 * side;
          x = k - 1 + r;
          y = -2 * k + 2 + 2 * r;
        end
      end
      c.idx = idx;
      c.x   = x[COORD_W-1:0];
      c.y   = y[COORD_W-1:0];
      return c;
    endfunction

    function void note_index(logic [IDX_W-1:0] idx);
      pending_q.push_back(locate_cell(idx));
    endfunction

    function void check_coord(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      hex_cell_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result (%0d, %0d)", x, y);
        end
        return;
      end
      e = pending_q.pop_front();
      if (x !== e.x || y !== e.y) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("index %0d: expected (%0d, %0d), got (%0d, %0d)", e.idx, e.x, e.y, x, y);
        end
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [IDX_W-1:0]          spiral_index_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [COORD_W-1:0] coord_x_o;
  logic signed [COORD_W-1:0] coord_y_o;

  hex_coord_board board = new();
  int unsigned    send_idle;
  int unsigned    recv_idle;
  int unsigned    cycles;

  hex_spiral_index_to_coord dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .spiral_index_i (spiral_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coord_x_o      (coord_x_o),
    .coord_y_o      (coord_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Index of the cell at position r (from 1) along ring k.
  function automatic logic [IDX_W-1:0] cell_at(longint unsigned k, longint unsigned r);
    return IDX_W'(hex_coord_board::ring_cells(k - 64'd1) + r - 64'd1);
  endfunction

  function automatic logic [IDX_W-1:0] random_index();
    logic [63:0]     raw;
    int unsigned     pick;
    longint unsigned k, off;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      return raw[IDX_W-1:0];
    end
    if (pick < 55) begin
      return IDX_W'(raw & ((64'd1 << $urandom_range(1, IDX_W)) - 64'd1));
    end
    if (pick < 70) begin
      return IDX_W'($urandom_range(0, 400));
    end
    k = (pick < 88) ? 64'($urandom_range(2, 2000)) : 64'($urandom_range(2, 32'(BIG_RING)));
    case ($urandom_range(0, 2))
      0:       off = 64'd1;
      1:       off = k - 64'd1;
      default: off = 64'($urandom_range(1, 32'(k - 64'd1)));
    endcase
    return cell_at(k, 64'($urandom_range(0, SIDES - 1)) * (k - 64'd1) + off);
  endfunction

  // Entered and left at a falling edge.
  task automatic push_index(logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    spiral_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    board.note_index(idx);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_coord(coord_x_o, coord_y_o);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    spiral_index_i = '0;
    out_ready_i    = 1'b0;
    cycles         = 0;
    send_idle      = 8;
    recv_idle      = 73;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The origin, every side of the first ring, the edges of the second, and the largest index and the top bit alone.
    for (int i = 0; i < 8; i++) begin
      push_index(IDX_W'(i));
    end
    push_index(IDX_W'(18));
    push_index(IDX_W'(19));
    push_index({IDX_W{1'b1}});
    push_index({1'b1, {(IDX_W-1){1'b0}}});
    // Every corner of a ring near the top of the index range, then the first cell of each later side of a smaller ring.
    push_index(cell_at(BIG_RING, 64'd1));
    for (int j = 1; j <= SIDES; j++) begin
      push_index(cell_at(BIG_RING, 64'(j) * (BIG_RING - 64'd1)));
    end
    for (int j = 1; j < SIDES; j++) begin
      push_index(cell_at(64'd1000, 64'(j) * 64'd999 + 64'd1));
    end

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle = 8;
          recv_idle = 73;
        end
        1: begin
          send_idle = 73;
          recv_idle = 8;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (RANDOM_PER_PASS) begin
        push_index(random_index());
      end
    end

    in_valid_i <= 1'b0;
    while (board.pending_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
